/* rtl/rfd_pkg.sv */
// ----------------------------------------------------------------------------
// rfd_pkg
// shared types and constants of the rpc frame deframer
// ----------------------------------------------------------------------------
package rfd_pkg;

    localparam int unsigned FIXED_BYTES = 26;
    localparam int unsigned SAT_LEN     = 8191;
    localparam int unsigned LEN_W       = 13;

    localparam logic       KIND_BYTE    = 1'b0;
    localparam logic       KIND_VERDICT = 1'b1;

    localparam logic [1:0] SEC_REQ_ID   = 2'd0;
    localparam logic [1:0] SEC_METHOD   = 2'd1;
    localparam logic [1:0] SEC_ERR_TEXT = 2'd2;
    localparam logic [1:0] SEC_PAYLOAD  = 2'd3;

    localparam logic [1:0] STAT_GOOD    = 2'd0;
    localparam logic [1:0] STAT_BAD_END = 2'd1;
    localparam logic [1:0] STAT_OVERRUN = 2'd2;

    localparam logic       REG_START    = 1'b0;
    localparam logic       REG_END      = 1'b1;

    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] end_marker;
    } cfg_t;

    typedef struct packed {
        logic               kind;
        logic [1:0]         section;
        logic [7:0]         out_byte;
        logic [1:0]         status;
        logic [LEN_W-1:0]   frame_length;
        logic [LEN_W-1:0]   req_id_length;
        logic [LEN_W-1:0]   method_name_length;
        logic [LEN_W-1:0]   err_info_length;
        logic signed [31:0] err_code;
        logic [31:0]        check_sum;
        logic               last;
    } result_t;

endpackage

/* rtl/rfd_if.sv */
// ----------------------------------------------------------------------------
// rfd_if
// valid/ready channels for the byte stream and the deframer results
// ----------------------------------------------------------------------------
interface rfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface rfd_result_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [1:0]         section;
    logic [7:0]         out_byte;
    logic [1:0]         status;
    logic [12:0]        frame_length;
    logic [12:0]        req_id_length;
    logic [12:0]        method_name_length;
    logic [12:0]        err_info_length;
    logic signed [31:0] err_code;
    logic [31:0]        check_sum;
    logic               last;

    modport source (
        output valid, output kind, output section, output out_byte, output status,
        output frame_length, output req_id_length, output method_name_length,
        output err_info_length, output err_code, output check_sum, output last,
        input ready
    );
    modport sink (
        input valid, input kind, input section, input out_byte, input status,
        input frame_length, input req_id_length, input method_name_length,
        input err_info_length, input err_code, input check_sum, input last,
        output ready
    );
endinterface

/* rtl/rfd_cfg.sv */
// ----------------------------------------------------------------------------
// rfd_cfg
// apb register file holding the start and end marker bytes
// ----------------------------------------------------------------------------
module rfd_cfg
    import rfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [7:0] start_reg;
    logic [7:0] end_reg;
    logic       wr_en;
    logic       reg_sel;

    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= 8'd2;
            end_reg   <= 8'd3;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_START: start_reg <= pwdata[7:0];
                REG_END:   end_reg   <= pwdata[7:0];
                default:   start_reg <= start_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_START: prdata = {24'd0, start_reg};
            REG_END:   prdata = {24'd0, end_reg};
            default:   prdata = 32'd0;
        endcase
    end

    assign cfg.start_marker = start_reg;
    assign cfg.end_marker   = end_reg;

endmodule

/* rtl/rfd_parser.sv */
// ----------------------------------------------------------------------------
// rfd_parser
// per-byte frame parser: phase, counters and held header fields
// ----------------------------------------------------------------------------
module rfd_parser
    import rfd_pkg::*;
#(
    parameter int unsigned MAX_FRAME = 4096
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] data_byte,
    input  cfg_t       cfg,
    output logic       res_valid,
    output result_t    res
);

    localparam int unsigned LW = $clog2(MAX_FRAME + 1);
    localparam int unsigned HW = (LW > LEN_W) ? LW : LEN_W;
    localparam logic [HW-1:0] HMAX = {HW{1'b1}};
    localparam logic [HW-1:0] HSAT = HW'(SAT_LEN);

    localparam logic [3:0] PH_HUNT   = 4'd0;
    localparam logic [3:0] PH_FLEN   = 4'd1;
    localparam logic [3:0] PH_RIDLEN = 4'd2;
    localparam logic [3:0] PH_RID    = 4'd3;
    localparam logic [3:0] PH_MLEN   = 4'd4;
    localparam logic [3:0] PH_METH   = 4'd5;
    localparam logic [3:0] PH_ECODE  = 4'd6;
    localparam logic [3:0] PH_ELEN   = 4'd7;
    localparam logic [3:0] PH_ETXT   = 4'd8;
    localparam logic [3:0] PH_PAY    = 4'd9;
    localparam logic [3:0] PH_CSUM   = 4'd10;
    localparam logic [3:0] PH_END    = 4'd11;
    localparam logic [3:0] PH_DRAIN  = 4'd12;

    logic [3:0]    phase_reg, phase_next;
    logic [LW-1:0] pos_reg, pos_next;
    logic [HW-1:0] flen_reg, flen_next;
    logic [31:0]   shift_reg, shift_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic [HW-1:0] rid_reg, rid_next;
    logic [HW-1:0] meth_reg, meth_next;
    logic [HW-1:0] eli_reg, eli_next;
    logic [LW-1:0] rem_reg, rem_next;
    logic [LW-1:0] spare_reg, spare_next;
    logic [31:0]   ecode_reg, ecode_next;
    logic [31:0]   csum_reg, csum_next;

    logic [31:0]   word;
    logic [LW-1:0] pos_inc;
    logic          over;
    logic [HW-1:0] word_sat;
    logic          word_zero;
    result_t       verdict;

    function automatic logic [LEN_W-1:0] sat_len(input logic [HW-1:0] v);
        sat_len = (v > HSAT) ? LEN_W'(SAT_LEN) : v[LEN_W-1:0];
    endfunction

    assign word      = {shift_reg[23:0], data_byte};
    assign pos_inc   = pos_reg + LW'(1);
    assign over      = word > {{(32 - LW){1'b0}}, spare_reg};
    assign word_sat  = (word > {{(32 - HW){1'b0}}, HMAX}) ? HMAX : word[HW-1:0];
    assign word_zero = (word == 32'd0);

    always_comb
    begin
        verdict                    = '0;
        verdict.kind               = KIND_VERDICT;
        verdict.frame_length       = sat_len(flen_reg);
        verdict.req_id_length      = sat_len(rid_reg);
        verdict.method_name_length = sat_len(meth_reg);
        verdict.err_info_length    = sat_len(eli_reg);
        verdict.err_code           = ecode_reg;
        verdict.check_sum          = csum_reg;
        verdict.last               = 1'b1;
    end

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        flen_next  = flen_reg;
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        rid_next   = rid_reg;
        meth_next  = meth_reg;
        eli_next   = eli_reg;
        rem_next   = rem_reg;
        spare_next = spare_reg;
        ecode_next = ecode_reg;
        csum_next  = csum_reg;
        res_valid  = 1'b0;
        res        = '0;

        if (take)
        begin
            if (phase_reg == PH_HUNT)
            begin
                if (data_byte == cfg.start_marker)
                begin
                    flen_next  = '0;
                    rid_next   = '0;
                    meth_next  = '0;
                    eli_next   = '0;
                    ecode_next = '0;
                    csum_next  = '0;
                    rem_next   = '0;
                    spare_next = '0;
                    shift_next = '0;
                    cnt_next   = '0;
                    pos_next   = LW'(1);
                    phase_next = PH_FLEN;
                end
            end
            else
            begin
                pos_next = pos_inc;
                case (phase_reg)
                    PH_FLEN, PH_RIDLEN, PH_MLEN, PH_ECODE, PH_ELEN, PH_CSUM:
                    begin
                        shift_next = word;
                        cnt_next   = cnt_reg + 2'd1;
                        if (cnt_reg == 2'd3)
                        begin
                            case (phase_reg)
                                PH_FLEN:
                                begin
                                    if (word < 32'(FIXED_BYTES) || word > 32'(MAX_FRAME))
                                    begin
                                        phase_next = PH_HUNT;
                                        pos_next   = '0;
                                    end
                                    else
                                    begin
                                        flen_next  = HW'(word[LW-1:0]);
                                        spare_next = word[LW-1:0] - LW'(FIXED_BYTES);
                                        phase_next = PH_RIDLEN;
                                    end
                                end
                                PH_RIDLEN:
                                begin
                                    rid_next = word_sat;
                                    if (over)
                                        phase_next = PH_DRAIN;
                                    else
                                    begin
                                        spare_next = spare_reg - word[LW-1:0];
                                        rem_next   = word[LW-1:0];
                                        cnt_next   = '0;
                                        phase_next = word_zero ? PH_MLEN : PH_RID;
                                    end
                                end
                                PH_MLEN:
                                begin
                                    meth_next = word_sat;
                                    if (over)
                                        phase_next = PH_DRAIN;
                                    else
                                    begin
                                        spare_next = spare_reg - word[LW-1:0];
                                        rem_next   = word[LW-1:0];
                                        cnt_next   = '0;
                                        phase_next = word_zero ? PH_ECODE : PH_METH;
                                    end
                                end
                                PH_ECODE:
                                begin
                                    ecode_next = word;
                                    phase_next = PH_ELEN;
                                end
                                PH_ELEN:
                                begin
                                    eli_next = word_sat;
                                    if (over)
                                        phase_next = PH_DRAIN;
                                    else
                                    begin
                                        spare_next = spare_reg - word[LW-1:0];
                                        cnt_next   = '0;
                                        if (word_zero)
                                        begin
                                            // empty error text: to payload or checksum
                                            rem_next   = spare_reg;
                                            phase_next = (spare_reg == '0) ? PH_CSUM : PH_PAY;
                                        end
                                        else
                                        begin
                                            rem_next   = word[LW-1:0];
                                            phase_next = PH_ETXT;
                                        end
                                    end
                                end
                                default:
                                begin
                                    csum_next  = word;
                                    phase_next = PH_END;
                                end
                            endcase
                        end
                    end
                    PH_RID, PH_METH, PH_ETXT, PH_PAY:
                    begin
                        res_valid    = 1'b1;
                        res.kind     = KIND_BYTE;
                        res.out_byte = data_byte;
                        case (phase_reg)
                            PH_RID:  res.section = SEC_REQ_ID;
                            PH_METH: res.section = SEC_METHOD;
                            PH_ETXT: res.section = SEC_ERR_TEXT;
                            default: res.section = SEC_PAYLOAD;
                        endcase
                        rem_next = rem_reg - LW'(1);
                        if (rem_reg == LW'(1))
                        begin
                            cnt_next = '0;
                            case (phase_reg)
                                PH_RID:  phase_next = PH_MLEN;
                                PH_METH: phase_next = PH_ECODE;
                                PH_ETXT:
                                begin
                                    rem_next   = spare_reg;
                                    phase_next = (spare_reg == '0) ? PH_CSUM : PH_PAY;
                                end
                                default: phase_next = PH_CSUM;
                            endcase
                        end
                    end
                    PH_END:
                    begin
                        res_valid  = 1'b1;
                        res        = verdict;
                        res.status = (data_byte == cfg.end_marker) ? STAT_GOOD : STAT_BAD_END;
                        phase_next = PH_HUNT;
                        pos_next   = '0;
                    end
                    PH_DRAIN:
                    begin
                        if (HW'(pos_inc) >= flen_reg)
                        begin
                            res_valid  = 1'b1;
                            res        = verdict;
                            res.status = STAT_OVERRUN;
                            phase_next = PH_HUNT;
                            pos_next   = '0;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HUNT;
                        pos_next   = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            pos_reg   <= '0;
            flen_reg  <= '0;
            shift_reg <= '0;
            cnt_reg   <= '0;
            rid_reg   <= '0;
            meth_reg  <= '0;
            eli_reg   <= '0;
            rem_reg   <= '0;
            spare_reg <= '0;
            ecode_reg <= '0;
            csum_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            flen_reg  <= flen_next;
            shift_reg <= shift_next;
            cnt_reg   <= cnt_next;
            rid_reg   <= rid_next;
            meth_reg  <= meth_next;
            eli_reg   <= eli_next;
            rem_reg   <= rem_next;
            spare_reg <= spare_next;
            ecode_reg <= ecode_next;
            csum_reg  <= csum_next;
        end
    end

    a_res_needs_take: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> take)
        else $error("result produced without an accepted byte");

    a_verdict_rehunts: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind == KIND_VERDICT) |=> phase_reg == PH_HUNT)
        else $error("parser not hunting after a verdict");

    a_drain_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DRAIN |-> HW'(pos_reg) < flen_reg)
        else $error("drain position past frame end");

endmodule

/* rtl/rfd_out_q.sv */
// ----------------------------------------------------------------------------
// rfd_out_q
// two-entry result queue between the parser and the result channel
// ----------------------------------------------------------------------------
module rfd_out_q
    import rfd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_en,
    input  result_t wr_data,
    output logic    not_full,
    output logic    rd_valid,
    input  logic    rd_ready,
    output result_t rd_data
);

    result_t    mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       rd_en;

    assign not_full = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_en    = rd_valid && rd_ready;
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        count_next  = count_reg + 2'(wr_en) - 2'(rd_en);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result queue count out of range");

    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> not_full)
        else $error("write into full result queue");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with count");

endmodule

/* rtl/rpc_frame_deframer.sv */
// ----------------------------------------------------------------------------
// rpc_frame_deframer
// byte-serial deframer for length-prefixed rpc frames
//
//   channel  | dir | handshake        | contents
//   stream   | in  | valid/ready      | data_byte, one stream byte
//   result   | out | valid/ready      | section byte or end-of-frame verdict
//   apb      | in  | psel/penable     | start_marker (0x0), end_marker (0x4)
//
// one byte per cycle while the queue has room; a result is visible the
// cycle after its byte is taken; results pass through a two-entry queue,
// so stream ready drops only when two results wait unread
// reset clears the parser to hunting and the markers to 0x02 / 0x03
// ----------------------------------------------------------------------------
module rpc_frame_deframer
    import rfd_pkg::*;
#(
    parameter int unsigned MAX_FRAME = 4096
)
(
    input  logic                clk,
    input  logic                rst_n,
    rfd_byte_if.sink            stream,
    rfd_result_if.source        result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    cfg_t    cfg;
    logic    take;
    logic    q_not_full;
    logic    res_valid;
    result_t res;
    result_t q_data;

    assign stream.ready = q_not_full;
    assign take         = stream.valid && q_not_full;

    rfd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rfd_parser #(
        .MAX_FRAME (MAX_FRAME)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .data_byte (stream.data_byte),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    rfd_out_q u_out_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (res_valid),
        .wr_data  (res),
        .not_full (q_not_full),
        .rd_valid (result.valid),
        .rd_ready (result.ready),
        .rd_data  (q_data)
    );

    assign result.kind               = q_data.kind;
    assign result.section            = q_data.section;
    assign result.out_byte           = q_data.out_byte;
    assign result.status             = q_data.status;
    assign result.frame_length       = q_data.frame_length;
    assign result.req_id_length      = q_data.req_id_length;
    assign result.method_name_length = q_data.method_name_length;
    assign result.err_info_length    = q_data.err_info_length;
    assign result.err_code           = q_data.err_code;
    assign result.check_sum          = q_data.check_sum;
    assign result.last               = q_data.last;

endmodule
